[design/mffg_pkg.sv]
package mffg_pkg;

    // Built grid size per axis
    localparam int GRID_N_DEFAULT = 16;

    // Field widths
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 32;
    localparam int COORD_W = 7;
    localparam int FORCE_W = 48;
    localparam int GN_W    = 5;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_GRID_N      = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INV_TWO_H   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SELECT_PREV = 2'd2;

    // Configuration reset values
    localparam logic [GN_W-1:0]  GRID_N_RESET    = 5'd16;
    localparam logic [VAL_W-1:0] INV_TWO_H_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        REQ_WR_CUR    = 2'd0,
        REQ_WR_PREV   = 2'd1,
        REQ_WR_CHARGE = 2'd2,
        REQ_QUERY     = 2'd3
    } req_t;

    // Neighbor offsets of the center point
    typedef enum logic [2:0] {
        OFF_PX,
        OFF_MX,
        OFF_PY,
        OFF_MY,
        OFF_PZ,
        OFF_MZ
    } off_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    typedef struct packed {
        logic  load;
        logic  wr_en;
        logic  rd_en;
        logic  rd_q;
        off_t  rd_off;
        logic  cap_plus;
        logic  mul_field;
        logic  mul_contrib;
        logic  acc_en;
        axis_t acc_axis;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic last;
        logic in_range;
        logic interior;
        logic out_free;
    } status_t;

endpackage

[design/mffg_ctrl.sv]
module mffg_ctrl
    import mffg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CTR,
        S_RUN,
        S_EMIT
    } state_t;

    localparam logic [3:0] LAST_STEP = 4'd8;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.rd_off   = OFF_PX;
        cmd.acc_axis = AX_X;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_CTR;
            end
            S_CTR:
            begin
                step_next = '0;
                if (!status.is_query)
                begin
                    cmd.wr_en  = status.in_range;
                    state_next = S_IDLE;
                end
                else if (status.interior)
                begin
                    state_next = S_RUN;
                end
                else if (status.last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                step_next = step_reg + 4'd1;
                // Reads of plus/minus neighbors interleave with the two multiplies
                case (step_reg)
                    4'd0:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_q   = 1'b1;
                        cmd.rd_off = OFF_PX;
                    end
                    4'd1:
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_off   = OFF_MX;
                        cmd.cap_plus = 1'b1;
                    end
                    4'd2:
                    begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_off    = OFF_PY;
                        cmd.mul_field = 1'b1;
                    end
                    4'd3:
                    begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_off      = OFF_MY;
                        cmd.cap_plus    = 1'b1;
                        cmd.mul_contrib = 1'b1;
                    end
                    4'd4:
                    begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_off    = OFF_PZ;
                        cmd.mul_field = 1'b1;
                        cmd.acc_en    = 1'b1;
                        cmd.acc_axis  = AX_X;
                    end
                    4'd5:
                    begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_off      = OFF_MZ;
                        cmd.cap_plus    = 1'b1;
                        cmd.mul_contrib = 1'b1;
                    end
                    4'd6:
                    begin
                        cmd.mul_field = 1'b1;
                        cmd.acc_en    = 1'b1;
                        cmd.acc_axis  = AX_Y;
                    end
                    4'd7:
                    begin
                        cmd.mul_contrib = 1'b1;
                    end
                    4'd8:
                    begin
                        cmd.acc_en   = 1'b1;
                        cmd.acc_axis = AX_Z;
                    end
                    default:
                    begin
                        cmd.acc_en = 1'b0;
                    end
                endcase
                if (step_reg == LAST_STEP)
                begin
                    state_next = status.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/mffg_dpath.sv]
module mffg_dpath
    import mffg_pkg::*;
#(
    parameter int GRID_N = GRID_N_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic [1:0]                 req_type,
    input  logic [IDX_W-1:0]           grid_index,
    input  logic signed [VAL_W-1:0]    write_value,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    input  logic                       neighbor_last,
    input  logic                       cfg_we,
    input  logic [CIDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [FORCE_W-1:0]  force_x,
    output logic signed [FORCE_W-1:0]  force_y,
    output logic signed [FORCE_W-1:0]  force_z
);

    localparam int DEPTH = GRID_N * GRID_N * GRID_N;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(GRID_N + 1);
    localparam int CNT_W = AW + 1;
    localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [48:0] NEG_LIMIT = 49'h0_8000_0000;
    localparam logic [48:0] POS_LIMIT = 49'h0_7FFF_FFFF;

    // Configuration
    logic [GN_W-1:0]  grid_n_reg;
    logic [VAL_W-1:0] inv_two_h_reg;
    logic             sel_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_n_reg    <= GRID_N_RESET;
            inv_two_h_reg <= INV_TWO_H_RESET;
            sel_prev_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_N:      grid_n_reg    <= cfg_data[GN_W-1:0];
                CFG_INV_TWO_H:   inv_two_h_reg <= cfg_data[VAL_W-1:0];
                CFG_SELECT_PREV: sel_prev_reg  <= cfg_data[0];
                default:         sel_prev_reg  <= sel_prev_reg;
            endcase
        end
    end

    // Active size, clamped to the built size, and its square and cube
    logic [NW-1:0]      n_act;
    logic [2*NW-1:0]    n_sq_full;
    logic [AW+NW-1:0]   n_cube_full;
    logic [AW-1:0]      n_sq_reg;
    logic [CNT_W-1:0]   n_cube_reg;

    always_comb
    begin
        if (7'(grid_n_reg) > 7'(GRID_N))
        begin
            n_act = NW'(GRID_N);
        end
        else
        begin
            n_act = NW'(grid_n_reg);
        end
    end

    assign n_sq_full   = n_act * n_act;
    assign n_cube_full = n_sq_reg * n_act;

    always_ff @(posedge clk)
    begin
        n_sq_reg   <= AW'(n_sq_full);
        n_cube_reg <= CNT_W'(n_cube_full);
    end

    // Item registers
    req_t                      type_reg;
    logic [IDX_W-1:0]          index_reg;
    logic signed [VAL_W-1:0]   value_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic                      last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= req_t'(req_type);
            index_reg <= grid_index;
            value_reg <= write_value;
            cx_reg    <= coord_x;
            cy_reg    <= coord_y;
            cz_reg    <= coord_z;
            last_reg  <= neighbor_last;
        end
    end

    // Interior test and write range
    logic signed [7:0] n_s, hi_s, cx_s, cy_s, cz_s;
    logic [CW-1:0]     idx_ext;

    assign n_s     = $signed(8'(n_act));
    assign hi_s    = n_s - 8'sd2;
    assign cx_s    = 8'(cx_reg);
    assign cy_s    = 8'(cy_reg);
    assign cz_s    = 8'(cz_reg);
    assign idx_ext = CW'(index_reg);

    logic out_valid_reg;

    assign status.is_query = (type_reg == REQ_QUERY);
    assign status.last     = last_reg;
    assign status.in_range = (idx_ext < CW'(n_cube_reg)) && (idx_ext < CW'(DEPTH));
    assign status.interior = (cx_s >= 8'sd1) && (cx_s <= hi_s)
                          && (cy_s >= 8'sd1) && (cy_s <= hi_s)
                          && (cz_s >= 8'sd1) && (cz_s <= hi_s);
    assign status.out_free = !out_valid_reg || out_ready;

    // Center address (x*n + y)*n + z over two stages
    logic [AW-1:0]    cx_u, cy_u, cz_u;
    logic [AW+NW-1:0] t1_full, c_full;
    logic [AW-1:0]    t1_reg, c_reg;

    assign cx_u    = AW'($unsigned(cx_reg));
    assign cy_u    = AW'($unsigned(cy_reg));
    assign cz_u    = AW'($unsigned(cz_reg));
    assign t1_full = cx_u * n_act + cy_u;
    assign c_full  = t1_reg * n_act + cz_u;

    always_ff @(posedge clk)
    begin
        t1_reg <= AW'(t1_full);
        c_reg  <= AW'(c_full);
    end

    // Neighbor read address
    logic [AW-1:0] rd_addr, step_n;

    assign step_n = AW'(n_act);

    always_comb
    begin
        case (cmd.rd_off)
            OFF_PX:  rd_addr = c_reg + n_sq_reg;
            OFF_MX:  rd_addr = c_reg - n_sq_reg;
            OFF_PY:  rd_addr = c_reg + step_n;
            OFF_MY:  rd_addr = c_reg - step_n;
            OFF_PZ:  rd_addr = c_reg + AW'(1);
            OFF_MZ:  rd_addr = c_reg - AW'(1);
            default: rd_addr = c_reg;
        endcase
    end

    // Grid memories
    logic [VAL_W-1:0]        cur_mem  [DEPTH];
    logic [VAL_W-1:0]        prev_mem [DEPTH];
    logic [VAL_W-1:0]        chg_mem  [DEPTH];
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] pot_rdata_reg, chg_rdata_reg;

    assign wr_addr = AW'(idx_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (type_reg == REQ_WR_CUR))
        begin
            cur_mem[wr_addr] <= value_reg;
        end
        if (cmd.wr_en && (type_reg == REQ_WR_PREV))
        begin
            prev_mem[wr_addr] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            pot_rdata_reg <= sel_prev_reg ? prev_mem[rd_addr] : cur_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (type_reg == REQ_WR_CHARGE))
        begin
            chg_mem[wr_addr] <= value_reg;
        end
        if (cmd.rd_q)
        begin
            chg_rdata_reg <= chg_mem[c_reg];
        end
    end

    // Field: |plus - minus| * inv_two_h, then saturate
    logic signed [VAL_W-1:0] plus_reg;
    logic signed [32:0]      diff;
    logic [32:0]             diff_mag;
    logic [64:0]             field_prod;
    logic [48:0]             prod_reg;
    logic                    neg_reg;

    assign diff       = 33'(plus_reg) - 33'(pot_rdata_reg);
    assign diff_mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign field_prod = diff_mag * inv_two_h_reg;

    // Contribution: |q| * |E| >> 16, signed
    logic [31:0]             emag, qmag;
    logic [63:0]             cprod;
    logic [47:0]             cmag;
    logic                    c_neg;
    logic signed [47:0]      contrib_next, contrib_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            emag = (prod_reg > NEG_LIMIT) ? 32'h8000_0000 : prod_reg[31:0];
        end
        else
        begin
            emag = (prod_reg > POS_LIMIT) ? 32'h7FFF_FFFF : prod_reg[31:0];
        end
    end

    assign qmag         = chg_rdata_reg[31] ? 32'(-chg_rdata_reg) : 32'(chg_rdata_reg);
    assign cprod        = qmag * emag;
    assign cmag         = cprod[63:16];
    assign c_neg        = chg_rdata_reg[31] ^ neg_reg;
    assign contrib_next = c_neg ? $signed(~cmag + 48'd1) : $signed(cmag);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_plus)
        begin
            plus_reg <= pot_rdata_reg;
        end
        if (cmd.mul_field)
        begin
            prod_reg <= field_prod[64:16];
            neg_reg  <= diff[32];
        end
        if (cmd.mul_contrib)
        begin
            contrib_reg <= contrib_next;
        end
    end

    // Saturating force accumulators
    logic signed [FORCE_W-1:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [FORCE_W-1:0] acc_x_next, acc_y_next, acc_z_next;
    logic signed [FORCE_W-1:0] acc_sel, acc_sat;
    logic signed [FORCE_W:0]   acc_diff;

    always_comb
    begin
        case (cmd.acc_axis)
            AX_X:    acc_sel = acc_x_reg;
            AX_Y:    acc_sel = acc_y_reg;
            AX_Z:    acc_sel = acc_z_reg;
            default: acc_sel = acc_x_reg;
        endcase
        acc_diff = (FORCE_W+1)'(acc_sel) - (FORCE_W+1)'(contrib_reg);
        if (acc_diff[FORCE_W] && !acc_diff[FORCE_W-1])
        begin
            acc_sat = {1'b1, {(FORCE_W-1){1'b0}}};
        end
        else if (!acc_diff[FORCE_W] && acc_diff[FORCE_W-1])
        begin
            acc_sat = {1'b0, {(FORCE_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_diff[FORCE_W-1:0];
        end

        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        acc_z_next = acc_z_reg;
        if (cmd.emit)
        begin
            acc_x_next = '0;
            acc_y_next = '0;
            acc_z_next = '0;
        end
        else if (cmd.acc_en)
        begin
            case (cmd.acc_axis)
                AX_X:    acc_x_next = acc_sat;
                AX_Y:    acc_y_next = acc_sat;
                AX_Z:    acc_z_next = acc_sat;
                default: acc_x_next = acc_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            acc_z_reg <= acc_z_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    logic signed [FORCE_W-1:0] force_x_reg, force_y_reg, force_z_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            force_x_reg <= acc_x_reg;
            force_y_reg <= acc_y_reg;
            force_z_reg <= acc_z_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x   = force_x_reg;
    assign force_y   = force_y_reg;
    assign force_z   = force_z_reg;

endmodule

[design/mesh_field_force_gather_core.sv]
// Particle-mesh force gather. The block keeps a current and a previous
// potential grid and a charge grid of GRID_N^3 signed Q16.16 entries in
// on-chip memories (no clearing after reset: read only entries already
// written). Write items (req_type 0..2) store one entry at grid_index;
// an index at or beyond grid_n^3 is dropped. A query item (req_type 3)
// names one neighbor point of a particle. At an interior point the block
// reads the six neighbors of the selected potential grid one per cycle
// through the single read port, forms each field component as a central
// difference times inv_two_h (saturated Q16.16), multiplies it by the
// charge at the point and subtracts the product from three saturating
// Q32.16 accumulators. The run of an interior query is set by the six
// potential reads and the two chained multiplies behind them; a boundary
// or outside point adds nothing. On the particle's last query an emit step
// moves the force into the output register and clears the accumulators;
// that step waits only while an earlier force item is still held there.
// in_ready is high whenever no item is in work, so a new item is taken
// while a finished force waits on the output. Configuration writes
// (index 0 grid_n, 1 inv_two_h, 2 select_previous) are always taken.
module mesh_field_force_gather_core
    import mffg_pkg::*;
#(
    parameter int GRID_N = GRID_N_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Input items
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 req_type,
    input  logic [IDX_W-1:0]           grid_index,
    input  logic signed [VAL_W-1:0]    write_value,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    input  logic                       neighbor_last,

    // Force items
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [FORCE_W-1:0]  force_x,
    output logic signed [FORCE_W-1:0]  force_y,
    output logic signed [FORCE_W-1:0]  force_z,

    // Configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CIDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    // Sequence item work: address, neighbor reads, multiplies, emission
    mffg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold grids, configuration, arithmetic, accumulators and output register
    mffg_dpath #(
        .GRID_N (GRID_N)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .grid_index    (grid_index),
        .write_value   (write_value),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .neighbor_last (neighbor_last),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z)
    );

endmodule

[tb/sv/mesh_field_force_gather_core_tb.sv]
module mesh_field_force_gather_core_tb;
    import mffg_pkg::*;

    localparam int GRID_N          = GRID_N_DEFAULT;
    localparam int DEPTH           = GRID_N * GRID_N * GRID_N;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 88;
    localparam int PHASE_PARTICLES = 8;
    localparam int SETTLE_CYCLES   = 24;
    localparam int MAX_PRINTED     = 40;
    localparam longint ACC_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN     = -ACC_MAX - 1;

    // One input item as the driver presents it
    typedef struct {
        req_t               kind;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   value;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic               last;
    } grid_req_t;

    // One force item as the block should emit it
    typedef struct {
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic signed [FORCE_W-1:0] fz;
    } force_vec_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic [1:0]                 req_type      = '0;
    logic [IDX_W-1:0]           grid_index    = '0;
    logic signed [VAL_W-1:0]    write_value   = '0;
    logic signed [COORD_W-1:0]  coord_x       = '0;
    logic signed [COORD_W-1:0]  coord_y       = '0;
    logic signed [COORD_W-1:0]  coord_z       = '0;
    logic                       neighbor_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic signed [FORCE_W-1:0]  force_x;
    logic signed [FORCE_W-1:0]  force_y;
    logic signed [FORCE_W-1:0]  force_z;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [CIDX_W-1:0]          cfg_index     = '0;
    logic [CFG_W-1:0]           cfg_data      = '0;

    // Predictor copy of the grids, accumulators and registers
    logic signed [VAL_W-1:0] cur_pot    [DEPTH];
    logic signed [VAL_W-1:0] prev_pot   [DEPTH];
    logic signed [VAL_W-1:0] charge_mem [DEPTH];
    longint                  acc_q [3]     = '{0, 0, 0};
    logic [GN_W-1:0]         grid_n_q      = GRID_N_RESET;
    logic [VAL_W-1:0]        inv_two_h_q   = INV_TWO_H_RESET;
    logic                    select_prev_q = 1'b0;

    grid_req_t  stim_q [$];
    force_vec_t pending_forces [$];

    // Generator view: which entries hold a written value, so that no query
    // ever reads an entry that was never filled
    bit   gen_written [3][DEPTH];
    int   gen_n;
    logic gen_sel;
    int   gen_items;
    int   gen_particles;

    int        sent_total     = 0;
    int        taken_total    = 0;
    int        forces_checked = 0;
    int        mismatch_count = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        stall_mode     = 0;
    int unsigned stall_cycle  = 0;
    grid_req_t next_req;

    mesh_field_force_gather_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .grid_index    (grid_index),
        .write_value   (write_value),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .neighbor_last (neighbor_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp the register value to the built grid size
    function automatic int active_size(logic [GN_W-1:0] g);
        return (int'(g) > GRID_N) ? GRID_N : int'(g);
    endfunction

    function automatic int grid_offset(int x, int y, int z, int n);
        return (x * n + y) * n + z;
    endfunction

    // Interior means every coordinate in 1..n-2; boundary and outside add nothing
    function automatic bit is_interior(int x, int y, int z, int n);
        return x >= 1 && x <= n - 2 && y >= 1 && y <= n - 2 && z >= 1 && z <= n - 2;
    endfunction

    function automatic longint potential_at(int i);
        return select_prev_q ? longint'(prev_pot[i]) : longint'(cur_pot[i]);
    endfunction

    // Q16.16 field from a 33-bit potential difference, truncated toward zero
    // and saturated to 32 bits
    function automatic longint field_component(longint diff, logic [VAL_W-1:0] scale);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (diff < 0) ? -diff : diff;
        prod = (mag * scale) >> 16;
        if (diff < 0)
            return (prod > 64'h8000_0000) ? -64'sd2147483648 : -longint'(prod);
        return (prod > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(prod);
    endfunction

    // Charge times field, Q32.16, truncated toward zero
    function automatic longint charge_product(longint q, longint e);
        longint unsigned mq;
        longint unsigned me;
        longint unsigned prod;
        mq   = (q < 0) ? -q : q;
        me   = (e < 0) ? -e : e;
        prod = (mq * me) >> 16;
        return ((q < 0) != (e < 0)) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint clamp_force(longint v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    // Apply one accepted item; queue a force vector on the particle's last query
    task automatic gather_step();
        int         n;
        int         x;
        int         y;
        int         z;
        int         c;
        int         stride [3];
        longint     q;
        longint     diff;
        force_vec_t fv;
        n = active_size(grid_n_q);
        if (req_type != REQ_QUERY)
        begin
            // drop writes beyond the active grid
            if (int'(grid_index) < n * n * n)
            begin
                case (req_type)
                    REQ_WR_CUR:  cur_pot[grid_index]    = write_value;
                    REQ_WR_PREV: prev_pot[grid_index]   = write_value;
                    default:     charge_mem[grid_index] = write_value;
                endcase
            end
        end
        else
        begin
            x = int'(coord_x);
            y = int'(coord_y);
            z = int'(coord_z);
            if (is_interior(x, y, z, n))
            begin
                c      = grid_offset(x, y, z, n);
                stride = '{n * n, n, 1};
                q      = longint'(charge_mem[c]);
                for (int a = 0; a < 3; a++)
                begin
                    diff     = potential_at(c + stride[a]) - potential_at(c - stride[a]);
                    acc_q[a] = clamp_force(acc_q[a] -
                                           charge_product(q, field_component(diff, inv_two_h_q)));
                end
            end
            // emit even when this last point itself was skipped
            if (neighbor_last)
            begin
                fv.fx = acc_q[0][FORCE_W-1:0];
                fv.fy = acc_q[1][FORCE_W-1:0];
                fv.fz = acc_q[2][FORCE_W-1:0];
                pending_forces.push_back(fv);
                acc_q = '{0, 0, 0};
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Mix of full-scale, zero, small and fully random Q16.16 values
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_coord();
        return int'($urandom_range(0, 127)) - 64;
    endfunction

    task automatic queue_write(input req_t kind, input int idx, input logic [VAL_W-1:0] v);
        grid_req_t r;
        r.kind  = kind;
        r.idx   = idx[IDX_W-1:0];
        r.value = v;
        r.cx    = 7'($urandom);
        r.cy    = 7'($urandom);
        r.cz    = 7'($urandom);
        r.last  = 1'($urandom);
        stim_q.push_back(r);
        sent_total++;
        // only writes that land count toward the phase budget
        if (idx < gen_n * gen_n * gen_n)
        begin
            gen_written[int'(kind)][idx] = 1'b1;
            gen_items++;
        end
    endtask

    // Fill whatever an interior query would read before queuing the query
    task automatic queue_query(input int x, input int y, input int z, input logic last);
        grid_req_t r;
        int        c;
        int        g;
        int        i;
        int        stride [3];
        if (is_interior(x, y, z, gen_n))
        begin
            c      = grid_offset(x, y, z, gen_n);
            g      = gen_sel ? 1 : 0;
            stride = '{gen_n * gen_n, gen_n, 1};
            if (!gen_written[2][c])
                queue_write(REQ_WR_CHARGE, c, pick_value());
            for (int a = 0; a < 3; a++)
            begin
                for (int sgn = -1; sgn <= 1; sgn += 2)
                begin
                    i = c + sgn * stride[a];
                    if (!gen_written[g][i])
                        queue_write(req_t'(g), i, pick_value());
                end
            end
        end
        r.kind  = REQ_QUERY;
        r.idx   = 12'($urandom);
        r.value = $urandom;
        r.cx    = 7'(x);
        r.cy    = 7'(y);
        r.cz    = 7'(z);
        r.last  = last;
        stim_q.push_back(r);
        sent_total++;
        gen_items++;
    endtask

    // A particle visits up to eight corners of one grid cell, or up to eight random points
    task automatic queue_particle();
        int count;
        int lim;
        int bx;
        int by;
        int bz;
        count = $urandom_range(1, 8);
        if (gen_n < 3 || $urandom_range(0, 7) == 0)
        begin
            for (int k = 0; k < count; k++)
                queue_query(pick_coord(), pick_coord(), pick_coord(), k == count - 1);
        end
        else
        begin
            // keep most particles near one corner so filled entries get reused
            lim = (gen_n > 7 && $urandom_range(0, 3) != 0) ? 5 : gen_n - 2;
            bx  = $urandom_range(0, lim);
            by  = $urandom_range(0, lim);
            bz  = $urandom_range(0, lim);
            if ($urandom_range(0, 7) == 0)
                bx = ($urandom_range(0, 1) != 0) ? -1 : gen_n - 1;
            for (int k = 0; k < count; k++)
                queue_query(bx + (k & 1), by + ((k >> 1) & 1), bz + ((k >> 2) & 1),
                            k == count - 1);
        end
        gen_particles++;
    endtask

    task automatic fill_random();
        while (gen_items < PHASE_ITEMS || gen_particles < PHASE_PARTICLES)
        begin
            case ($urandom_range(0, 9))
                0:       queue_write(req_t'($urandom_range(0, 2)),
                                     $urandom_range(0, DEPTH - 1), pick_value());
                1:       queue_query(pick_coord(), pick_coord(), pick_coord(), 1'($urandom));
                default: queue_particle();
            endcase
        end
    endtask

    // Run under the reset settings with the built size of 16
    task automatic directed_items();
        int c;
        c = grid_offset(1, 1, 1, gen_n);
        // x difference at positive full scale, y at negative, z flat
        queue_write(REQ_WR_CUR, c + gen_n * gen_n, 32'h7FFF_FFFF);
        queue_write(REQ_WR_CUR, c - gen_n * gen_n, 32'h8000_0000);
        queue_write(REQ_WR_CUR, c + gen_n, 32'h8000_0000);
        queue_write(REQ_WR_CUR, c - gen_n, 32'h7FFF_FFFF);
        queue_write(REQ_WR_CUR, c + 1, 32'h0001_2345);
        queue_write(REQ_WR_CUR, c - 1, 32'h0001_2345);
        queue_write(REQ_WR_CHARGE, c, 32'h8000_0000);
        // three full-scale hits drive both accumulators into saturation
        queue_query(1, 1, 1, 1'b0);
        queue_query(1, 1, 1, 1'b0);
        queue_query(1, 1, 1, 1'b1);
        queue_write(REQ_WR_PREV, 0, 32'h7FFF_FFFF);
        queue_write(REQ_WR_CHARGE, DEPTH - 1, 32'hFFFF_FFFF);
        // boundary points, then outside last points that still emit, then interior points at the upper limit
        queue_query(0, 5, 5, 1'b0);
        queue_query(gen_n - 1, gen_n - 1, gen_n - 1, 1'b0);
        queue_query(-64, 63, -1, 1'b1);
        queue_query(63, -64, gen_n, 1'b1);
        queue_query(gen_n - 2, gen_n - 2, gen_n - 2, 1'b1);
        queue_query(7, 1, gen_n - 2, 1'b0);
        queue_query(7, 1, gen_n - 2, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Configuration writes, only while the block is idle
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_phase(input logic [GN_W-1:0] gn, input logic [VAL_W-1:0] inv,
                             input logic sel);
        write_reg(CFG_GRID_N, CFG_W'(gn));
        write_reg(CFG_INV_TWO_H, inv);
        write_reg(CFG_SELECT_PREV, CFG_W'(sel));
        gen_n   = active_size(gn);
        gen_sel = sel;
    endtask

    // Hold until every item is taken and every force item is back, then let
    // a trailing write or non-last query finish inside the block
    task automatic wait_idle();
        while (taken_total < sent_total || pending_forces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps; also tracks register writes
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_N:      grid_n_q      = cfg_data[GN_W-1:0];
                    CFG_INV_TWO_H:   inv_two_h_q   = cfg_data;
                    CFG_SELECT_PREV: select_prev_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                gather_step();
                taken_total++;
            end
            // advance only when nothing is held waiting for ready
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_q.size() != 0)
                begin
                    next_req = stim_q.pop_front();
                    req_type      <= next_req.kind;
                    grid_index    <= next_req.idx;
                    write_value   <= next_req.value;
                    coord_x       <= next_req.cx;
                    coord_y       <= next_req.cy;
                    coord_z       <= next_req.cz;
                    neighbor_last <= next_req.last;
                    in_valid      <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // long back-to-back stretches now and then
                        burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check force items, stall on a shifting pattern
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_mode  = 0;
            stall_cycle = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_forces.size() == 0)
                    report_mismatch("force item with nothing expected");
                else
                begin
                    forces_checked++;
                    if (force_x !== pending_forces[0].fx)
                        report_mismatch($sformatf("force_x got %0d want %0d",
                                                  force_x, pending_forces[0].fx));
                    if (force_y !== pending_forces[0].fy)
                        report_mismatch($sformatf("force_y got %0d want %0d",
                                                  force_y, pending_forces[0].fy));
                    if (force_z !== pending_forces[0].fz)
                        report_mismatch($sformatf("force_z got %0d want %0d",
                                                  force_z, pending_forces[0].fz));
                    void'(pending_forces.pop_front());
                end
            end
            stall_cycle++;
            if (stall_cycle % 96 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom);
                2:       out_ready <= ($urandom_range(0, 4) == 0);
                default: out_ready <= stall_cycle[3];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            gen_items     = 0;
            gen_particles = 0;
            case (ph)
                0:
                begin
                    gen_n   = active_size(GRID_N_RESET);
                    gen_sel = 1'b0;
                    directed_items();
                end
                1: set_phase(5'd3, 32'hFFFF_FFFF, 1'b1);
                2: set_phase(5'd16, 32'h0000_0000, 1'b0);
                // too small for any interior point
                3: set_phase(5'd2, $urandom, 1'b1);
                // above the built size, treated as the built size
                4: set_phase(5'd31, 32'h0001_0000, 1'b1);
                5: set_phase(5'($urandom_range(3, 16)), $urandom_range(0, 32'h0004_0000),
                             1'($urandom));
                6: set_phase(5'($urandom_range(3, 16)), $urandom, 1'($urandom));
                default: set_phase(5'd5, 32'h0000_8000, 1'b0);
            endcase
            fill_random();
            wait_idle();
        end
        $display("summary: %0d items over %0d register settings, %0d force items checked",
                 taken_total, PHASES, forces_checked);
        $display("summary: %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout: %0d of %0d items taken, %0d force items outstanding",
                 taken_total, sent_total, pending_forces.size());
        $display("status: fail");
        $finish;
    end

endmodule
